FILE: sv/lfsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared constants and the request record that moves down the slot chain.
// ----------------------------------------------------------------------------
package lfsa_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int TIME_BITS = 32;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    // Port field widths
    localparam int SLOT_IDX_W  = 6;
    localparam int SLOTS_USE_W = 7;
    localparam int IN_DATA_W   = 2 * TIME_BITS;
    localparam int OUT_FIELD_W = SLOT_IDX_W + SLOTS_USE_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        logic             valid;
        logic             new_group;
        time_t            arrival;
        time_t            leave;
        logic             found;
        logic [IDX_W-1:0] pick;
        logic [CNT_W-1:0] used;
    } lfsa_req_t;

endpackage

`default_nettype wire

FILE: sv/lowest_free_slot_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator
// Lowest-free-slot allocator built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Each request walks a chain of MAX_SLOTS cells (64), each of which registers
// it before handing it on; its result is offered on the output from the
// register of the last cell. While the output is not stalled, one request
// enters every cycle. Cell i owns slot i:
// it frees itself when the passing arrival is at or after its stored leave
// time, and the first free cell claims the request. Because requests keep
// their order along the chain, every request sees the slot state left by all
// earlier ones. The whole chain advances together; it holds while the output
// transfer is stalled, and s_axis_tready follows that.
module lowest_free_slot_allocator (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] arrival_time, [63:32] leave_time
    input  wire [lfsa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] new_group
    input  wire                                s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [5:0] slot_index, [12:6] slots_used, [15:13] zero
    output logic [lfsa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] full_res
    output logic                               m_axis_tuser
);
    import lfsa_pkg::*;

    lfsa_req_t chain [0:MAX_SLOTS];
    logic      adv;
    lfsa_req_t head;
    lfsa_req_t tail;

    assign adv           = !chain[MAX_SLOTS].valid || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        head           = '0;
        head.valid     = s_axis_tvalid;
        head.new_group = s_axis_tuser;
        head.arrival   = s_axis_tdata[TIME_BITS-1:0];
        head.leave     = s_axis_tdata[IN_DATA_W-1:TIME_BITS];
    end

    assign chain[0] = head;

    for (genvar i = 0; i < MAX_SLOTS; i++)
    begin : g_cell
        lfsa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .cell_idx (IDX_W'(i)),
            .req_in   (chain[i]),
            .req_out  (chain[i+1])
        );
    end

    assign tail = chain[MAX_SLOTS];

    always_comb
    begin
        m_axis_tvalid = tail.valid;
        m_axis_tuser  = !tail.found;
        m_axis_tdata  = '0;
        m_axis_tdata[SLOT_IDX_W-1:0] =
            tail.found ? SLOT_IDX_W'(tail.pick) : '0;
        m_axis_tdata[OUT_FIELD_W-1:SLOT_IDX_W] = SLOTS_USE_W'(tail.used);
    end

endmodule

`default_nettype wire

FILE: sv/lfsa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfsa_cell
// One slot: holds its release time and used flag, claims a passing request
// when free and not yet claimed upstream, and hands the request on.
// ----------------------------------------------------------------------------
module lfsa_cell (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       adv,
    input  wire [lfsa_pkg::IDX_W-1:0] cell_idx,
    input  wire lfsa_pkg::lfsa_req_t  req_in,
    output lfsa_pkg::lfsa_req_t       req_out
);
    import lfsa_pkg::*;

    time_t     release_reg;
    logic      used_reg;
    lfsa_req_t req_reg;

    time_t            rel_eff;
    logic             used_eff;
    logic             claim;
    logic [CNT_W-1:0] idx_plus;
    lfsa_req_t        req_next;

    always_comb
    begin
        // a new group sees every slot cleared
        rel_eff  = req_in.new_group ? '0 : release_reg;
        used_eff = req_in.new_group ? 1'b0 : used_reg;
        claim    = req_in.valid && !req_in.found && (rel_eff <= req_in.arrival);
        idx_plus = CNT_W'(cell_idx) + CNT_W'(1);

        req_next = req_in;
        if (claim)
        begin
            req_next.found = 1'b1;
            req_next.pick  = cell_idx;
        end
        if (used_eff || claim)
        begin
            req_next.used = idx_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_reg <= '0;
            used_reg    <= 1'b0;
            req_reg     <= '0;
        end
        else if (adv)
        begin
            req_reg <= req_next;
            if (claim)
            begin
                release_reg <= req_in.leave;
                used_reg    <= 1'b1;
            end
            else if (req_in.valid && req_in.new_group)
            begin
                release_reg <= '0;
                used_reg    <= 1'b0;
            end
        end
    end

    assign req_out = req_reg;

endmodule

`default_nettype wire

FILE: sv/lfsa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfsa_checker
// Port-level checks for the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module lfsa_checker (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             s_axis_tready,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [lfsa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input wire                             m_axis_tuser
);
    import lfsa_pkg::*;

    // input side opens exactly when the output side can move
    a_ready_follows_out : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("s_axis_tready does not track output stall");

    // a full result means every slot was used
    a_full_all_used : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[OUT_FIELD_W-1:SLOT_IDX_W] == SLOTS_USE_W'(MAX_SLOTS)
             && m_axis_tdata[SLOT_IDX_W-1:0] == '0))
        else $error("full result with free slots or nonzero index");

    // a placed request lies inside the used prefix
    a_slot_in_used : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
            (SLOTS_USE_W'(m_axis_tdata[SLOT_IDX_W-1:0])
             < m_axis_tdata[OUT_FIELD_W-1:SLOT_IDX_W]))
        else $error("slot index outside used count");

    // stalled output transfer holds
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output changed while stalled");

endmodule

bind lowest_free_slot_allocator lfsa_checker u_lfsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: bench/slot_alloc_checker.sv
// ----------------------------------------------------------------------------
// slot_alloc_checker
// Watches both stream channels of the lowest-free-slot allocator. It tracks
// its own per-slot leave times and used count, predicts the grant of every
// request transfer, and compares each result transfer with the oldest
// pending grant.
// ----------------------------------------------------------------------------
module slot_alloc_checker (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    input  wire                                s_tready,
    input  wire [lfsa_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire                                s_tuser,
    input  wire                                m_tvalid,
    input  wire                                m_tready,
    input  wire [lfsa_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  wire                                m_tuser,
    output int                                 mismatches,
    output int                                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB = lfsa_pkg::TIME_BITS;
    localparam int IW = lfsa_pkg::SLOT_IDX_W;
    localparam int UW = lfsa_pkg::SLOTS_USE_W;

    typedef struct packed {
        logic [IW-1:0] slot_index;
        logic [UW-1:0] slots_used;
        logic          full_res;
    } grant_t;

    lfsa_pkg::time_t busy_until [lfsa_pkg::MAX_SLOTS];
    logic [UW-1:0]   group_used;
    grant_t          pending_grants [$];
    int              fail_count = 0;
    int              grant_count = 0;

    assign mismatches  = fail_count;
    assign outstanding = grant_count;

    // Clear all slots on a new group, then claim the lowest slot whose leave time is at or before the arrival.
    function automatic grant_t assign_lowest_slot(input lfsa_pkg::time_t arr,
                                                  input lfsa_pkg::time_t lv,
                                                  input logic grp);
        grant_t g;
        int     pick;
        pick = -1;
        if (grp)
        begin
            for (int i = 0; i < lfsa_pkg::MAX_SLOTS; i++)
                busy_until[i] = '0;
            group_used = '0;
        end
        for (int i = 0; i < lfsa_pkg::MAX_SLOTS; i++)
        begin
            if (pick < 0 && busy_until[i] <= arr)
                pick = i;
        end
        if (pick >= 0)
        begin
            busy_until[pick] = lv;
            if (pick + 1 > group_used)
                group_used = UW'(pick + 1);
            g.slot_index = IW'(pick);
            g.slots_used = group_used;
            g.full_res   = 1'b0;
        end
        else
        begin
            g.slot_index = '0;
            g.slots_used = group_used;
            g.full_res   = 1'b1;
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        grant_t want;
        grant_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < lfsa_pkg::MAX_SLOTS; i++)
                busy_until[i] = '0;
            group_used = '0;
            pending_grants.delete();
            grant_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_grants.size() == 0)
                begin
                    $error("result transfer with no pending grant: slot_index %0d",
                           m_tdata[IW-1:0]);
                    fail_count++;
                end
                else
                begin
                    want = pending_grants.pop_front();
                    if (m_tdata[IW-1:0] !== want.slot_index)
                    begin
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, m_tdata[IW-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[IW +: UW] !== want.slots_used)
                    begin
                        $error("slots_used: expected %0d, got %0d",
                               want.slots_used, m_tdata[IW +: UW]);
                        fail_count++;
                    end
                    if (m_tuser !== want.full_res)
                    begin
                        $error("full_res: expected %0d, got %0d", want.full_res, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                fresh = assign_lowest_slot(s_tdata[TB-1:0], s_tdata[2*TB-1:TB], s_tuser);
                pending_grants = {pending_grants, fresh};
            end
            grant_count = pending_grants.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives slot requests into the lowest-free-slot allocator: a short directed
// list of edge cases, then random groups of ordered requests (steady load,
// groups packed past every slot, and raw noise), with random gaps on both
// sides and one long output hold-off. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1200;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 2 * lfsa_pkg::MAX_SLOTS + 20;

    typedef enum int {GRP_STEADY, GRP_PACKED, GRP_NOISE} grp_kind_t;

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    wire                                s_tready;
    logic [lfsa_pkg::IN_DATA_W-1:0]     s_tdata;
    logic                               s_tuser;
    wire                                m_tvalid;
    logic                               m_tready;
    wire  [lfsa_pkg::OUT_DATA_W-1:0]    m_tdata;
    wire                                m_tuser;

    int mismatches;
    int outstanding;
    int sent = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    lowest_free_slot_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    slot_alloc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly no gap, often short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request from a falling edge; return at the falling edge after its transfer.
    task automatic send_req(input lfsa_pkg::time_t arr, input lfsa_pkg::time_t lv,
                            input logic grp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lv, arr};
        s_tuser  <= grp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // Result side: random ready bursts and stalls, plus the one long hold-off.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat (quiet ? 200 : $urandom_range(1, 24)) @(negedge clk);
                stall = pick_gap();
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
        end
    end

    // Count cycles with no transfer on either channel.
    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        lfsa_pkg::time_t arr;
        lfsa_pkg::time_t base;
        grp_kind_t       kind;
        int              n;
        int              span;
        int              step_max;
        int              extra;
        int              r;
        bit              grp;
        bit              first_grp;
        bit              hold_done;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, reuse at equal times, out-of-order arrival, early leave.
        send_req(32'h0000_0000, 32'h0000_0000, 1'b1);
        send_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_req(32'd5, 32'd10, 1'b0);
        send_req(32'd10, 32'd20, 1'b0);
        send_req(32'd3, 32'd4, 1'b0);
        send_req(32'd7, 32'd7, 1'b0);
        send_req(32'd8, 32'd2, 1'b0);
        send_req(32'd9, 32'd12, 1'b0);
        send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_req(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_req(32'd0, 32'd1, 1'b1);
        send_req(32'd0, 32'd1, 1'b0);
        send_req(32'd1, 32'hFFFF_FFFE, 1'b0);
        send_req(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        send_req(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);

        first_grp = 1'b1;
        hold_done = 1'b0;
        n = sent + RANDOM_ITEMS;
        while (sent < n)
        begin
            if (!hold_done && sent >= 500)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            quiet = (sent >= 800 && sent < 950);
            r = $urandom_range(0, 99);
            if (first_grp)
                kind = GRP_PACKED;
            else if (r < 60)
                kind = GRP_STEADY;
            else if (r < 75)
                kind = GRP_PACKED;
            else
                kind = GRP_NOISE;
            first_grp = 1'b0;

            case (kind)
                GRP_STEADY:
                begin
                    arr      = $urandom;
                    grp      = ($urandom_range(0, 3) != 0);
                    span     = $urandom_range(1, 300);
                    step_max = $urandom_range(0, 4);
                    repeat ($urandom_range(10, 60))
                    begin
                        send_req(arr, arr + $urandom_range(1, span), grp);
                        grp = 1'b0;
                        arr = arr + $urandom_range(0, step_max);
                    end
                end
                GRP_PACKED:
                begin
                    // Overfill every slot at one arrival, then advance to free some.
                    base  = $urandom_range(0, 32'h7FFF_FFFF);
                    extra = $urandom_range(1, 4);
                    grp   = 1'b1;
                    repeat (lfsa_pkg::MAX_SLOTS + extra)
                    begin
                        send_req(base, base + 1000 + $urandom_range(0, 1000), grp);
                        grp = 1'b0;
                    end
                    arr = base + 1000;
                    repeat ($urandom_range(8, 30))
                    begin
                        arr = arr + $urandom_range(0, 60);
                        send_req(arr, arr + $urandom_range(1, 1500), 1'b0);
                    end
                end
                default:
                begin
                    repeat ($urandom_range(1, 5))
                        send_req($urandom, $urandom, $urandom_range(0, 3) == 0);
                end
            endcase
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: lowest_free_slot_allocator.f
sv/lfsa_pkg.sv
sv/lfsa_cell.sv
sv/lowest_free_slot_allocator.sv
sv/lfsa_checker.sv
bench/slot_alloc_checker.sv
bench/tb_top.sv
